### design/lgsf_pkg.sv
// ----------------------------------------------------------------------------
// lgsf_pkg
//
// Shared types and constants for the life grid with fading trails.
// ----------------------------------------------------------------------------
package lgsf_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Coordinates and grid sizes follow the 7-bit size registers.
  localparam int CRD_W = 7;

  localparam logic [7:0] LIVE = 8'hFF;

  typedef logic [CRD_W-1:0] crd_t;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_DRAW = 2'd1,
    FUNC_STEP = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_FADE_STEP   = 2'd2
  } cfg_reg_t;

  // Which row of the three-row column a neighborhood read belongs to.
  typedef enum logic [1:0] {
    ROW_ABOVE  = 2'd0,
    ROW_CENTER = 2'd1,
    ROW_BELOW  = 2'd2
  } row_sel_t;

  // Tag that travels with a neighborhood read issued to the cell memory.
  typedef struct packed {
    logic           valid;
    row_sel_t       row;
    logic [CRD_W:0] col;
    crd_t           y;
  } fetch_tag_t;

  // Next-generation liveness for one cell.
  typedef struct packed {
    logic valid;
    crd_t x;
    crd_t y;
    logic alive;
  } eval_t;

endpackage

### design/lgsf_window.sv
// ----------------------------------------------------------------------------
// lgsf_window
//
// Sliding 3x3 liveness window. Columns arrive as three reads each; after a
// full column the window shifts and the cell in its middle is evaluated.
// ----------------------------------------------------------------------------
module lgsf_window (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lgsf_pkg::fetch_tag_t   tag_i,
  input  logic                   live_i,
  output lgsf_pkg::eval_t        eval_o,
  output logic                   busy_o
);
  import lgsf_pkg::*;

  fetch_tag_t tag_r;
  eval_t      eval_r;
  logic       top_r;
  logic       mid_r;
  logic [2:0] center_r;
  logic [2:0] right_r;
  logic [2:0] col_new;
  logic [3:0] count;
  logic       alive_nxt;

  // Bit 0 is the row above, bit 1 the center row, bit 2 the row below.
  assign col_new = {live_i, mid_r, top_r};

  // Window after the shift: center_r | right_r | col_new. Its center is
  // right_r[1], which is left out of the count.
  always_comb begin
    count = 4'(center_r[0]) + 4'(center_r[1]) + 4'(center_r[2])
          + 4'(right_r[0]) + 4'(right_r[2])
          + 4'(col_new[0]) + 4'(col_new[1]) + 4'(col_new[2]);
    alive_nxt = (count == 4'd3) || (right_r[1] && (count == 4'd2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid  <= 1'b0;
      eval_r.valid <= 1'b0;
    end else begin
      tag_r.valid  <= tag_i.valid;
      eval_r.valid <= tag_r.valid && (tag_r.row == ROW_BELOW)
                      && (tag_r.col >= (CRD_W+1)'(2));
    end
    tag_r.row <= tag_i.row;
    tag_r.col <= tag_i.col;
    tag_r.y   <= tag_i.y;
    if (tag_r.valid) begin
      case (tag_r.row)
        ROW_ABOVE: begin
          top_r <= live_i;
        end
        ROW_CENTER: begin
          mid_r <= live_i;
        end
        default: begin
          center_r     <= right_r;
          right_r      <= col_new;
          eval_r.x     <= crd_t'(tag_r.col - (CRD_W+1)'(2));
          eval_r.y     <= tag_r.y;
          eval_r.alive <= alive_nxt;
        end
      endcase
    end
  end

  assign eval_o = eval_r;
  assign busy_o = tag_r.valid || eval_r.valid;

endmodule

### design/life_grid_step_with_fade.sv
// ----------------------------------------------------------------------------
// life_grid_step_with_fade
//
// Grid of 8-bit cell intensities (255 is alive) with toroidal B3S23 steps and
// fading trails. Items carry a function code: load writes one cell, draw
// toggles one cell (live goes to 255 minus fade_step, anything else to 255),
// read returns one cell, and step computes one generation over the grid in
// use. Every item gives exactly one result beat. The cells live in a memory
// with one read and one write port and a registered read. A load writes its
// cell as it is taken, while a read or draw first waits for the registered
// read. In a step the neighborhood pass reads three cells per window column
// over that single read port, and the fade pass reads and writes back one
// cell per cycle. After reset the block sweeps all MAX_WIDTH*MAX_HEIGHT
// entries of the cell memory to zero, one entry per cycle; it takes no item
// during that time, while configuration writes are taken at any time.
// Results wait in an output register, so the block takes a new item while
// the previous result beat has not yet been taken.
// ----------------------------------------------------------------------------
module life_grid_step_with_fade #(
  parameter int MAX_WIDTH  = lgsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lgsf_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Item channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cell_x[5:0], cell_y[11:6], cell_value[19:12], zeros
  input  logic [1:0]  in_tuser,   // func[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // read_value[7:0]
  output logic        out_tuser,  // accepted[0]
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lgsf_pkg::*;

  localparam int NCELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int CRD_MAX = (1 << CRD_W) - 1;
  localparam crd_t W_CAP = crd_t'((MAX_WIDTH > CRD_MAX) ? CRD_MAX : MAX_WIDTH);
  localparam crd_t H_CAP = crd_t'((MAX_HEIGHT > CRD_MAX) ? CRD_MAX : MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NCELLS - 1);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_READ    = 9'b000000100,
    ST_DRAW    = 9'b000001000,
    ST_GEN_A   = 9'b000010000,
    ST_DRAIN_A = 9'b000100000,
    ST_GEN_B   = 9'b001000000,
    ST_DRAIN_B = 9'b010000000,
    ST_RESP    = 9'b100000000
  } state_t;

  // Row-major address with a row stride of MAX_WIDTH.
  function automatic logic [ADDR_W-1:0] cell_addr(input crd_t x, input crd_t y);
    return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
  endfunction

  state_t             st_r, st_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  crd_t               gy_r, gy_nxt;
  logic [CRD_W:0]     gk_r, gk_nxt;
  row_sel_t           gr_r, gr_nxt;
  logic [7:0]         res_r, res_nxt;
  logic [ADDR_W-1:0]  item_addr_r;
  logic               wb_v_r;
  logic [ADDR_W-1:0]  wb_addr_r;
  logic               out_valid_r;
  logic [7:0]         out_data_r;

  crd_t               gw_r;
  crd_t               gh_r;
  logic [7:0]         fade_r;

  // Memories and their ports.
  logic [7:0]         cell_mem [NCELLS];
  logic               nam_mem  [NCELLS];
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data_r;
  logic               nam_rd_r;
  logic               cell_we;
  logic [ADDR_W-1:0]  cell_wa;
  logic [7:0]         cell_wd;

  // Item decode.
  logic               accept;
  func_t              in_func;
  crd_t               in_x;
  crd_t               in_y;
  crd_t               x_cl;
  crd_t               y_cl;
  logic [ADDR_W-1:0]  item_addr;
  logic [7:0]         in_value;

  // Grid geometry in use.
  crd_t               w_used;
  crd_t               h_used;
  crd_t               w_last;
  crd_t               h_last;

  // Generation sequencing.
  crd_t               ga_row;
  crd_t               ga_col;
  logic [CRD_W:0]     ga_km1;
  logic [ADDR_W-1:0]  ga_addr;
  logic [ADDR_W-1:0]  gb_addr;
  fetch_tag_t         issue_tag;
  eval_t              eval;
  logic               win_busy;
  logic [7:0]         draw_val;
  logic [7:0]         fade_val;
  logic               out_free;

  // ---------------------------------------------------------------------
  // Configuration registers. The port never stalls; an index past the
  // register list is taken and ignored.
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= crd_t'(64);
      gh_r   <= crd_t'(64);
      fade_r <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  gw_r   <= cfg_data[CRD_W-1:0];
        REG_GRID_HEIGHT: gh_r   <= cfg_data[CRD_W-1:0];
        REG_FADE_STEP:   fade_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A size of zero acts as one; a size above the memory acts as its limit.
  assign w_used = (gw_r == '0) ? crd_t'(1) : ((gw_r > W_CAP) ? W_CAP : gw_r);
  assign h_used = (gh_r == '0) ? crd_t'(1) : ((gh_r > H_CAP) ? H_CAP : gh_r);
  assign w_last = w_used - crd_t'(1);
  assign h_last = h_used - crd_t'(1);

  // ---------------------------------------------------------------------
  // Item decode. Addresses saturate to the last column and row in use.
  // ---------------------------------------------------------------------
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) || ((st_r == ST_RESP) && out_free);
  assign accept    = in_tvalid && in_tready;

  assign in_func   = func_t'(in_tuser);
  assign in_x      = {1'b0, in_tdata[5:0]};
  assign in_y      = {1'b0, in_tdata[11:6]};
  assign in_value  = in_tdata[19:12];
  assign x_cl      = (in_x > w_last) ? w_last : in_x;
  assign y_cl      = (in_y > h_last) ? h_last : in_y;
  assign item_addr = cell_addr(x_cl, y_cl);

  // ---------------------------------------------------------------------
  // Neighborhood pass. For row y the window columns are fetched in the
  // order w-1, 0, 1, ..., w-1, 0 so that both wrap columns are covered;
  // each column is three reads (row above, row, row below, all wrapped).
  // ---------------------------------------------------------------------
  always_comb begin
    case (gr_r)
      ROW_ABOVE:  ga_row = (gy_r == '0) ? h_last : gy_r - crd_t'(1);
      ROW_CENTER: ga_row = gy_r;
      ROW_BELOW:  ga_row = (gy_r == h_last) ? crd_t'(0) : gy_r + crd_t'(1);
      default:    ga_row = gy_r;
    endcase
  end

  assign ga_km1  = gk_r - (CRD_W+1)'(1);
  assign ga_col  = (gk_r == '0) ? w_last
                 : ((ga_km1 == {1'b0, w_used}) ? crd_t'(0) : ga_km1[CRD_W-1:0]);
  assign ga_addr = cell_addr(ga_col, ga_row);

  // Fade pass walks the grid in row order, one cell per cycle.
  assign gb_addr = cell_addr(gk_r[CRD_W-1:0], gy_r);

  always_comb begin
    issue_tag.valid = (st_r == ST_GEN_A);
    issue_tag.row   = gr_r;
    issue_tag.col   = gk_r;
    issue_tag.y     = gy_r;
  end

  lgsf_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (issue_tag),
    .live_i (rd_data_r == LIVE),
    .eval_o (eval),
    .busy_o (win_busy)
  );

  always_comb begin
    case (st_r)
      ST_GEN_A: rd_addr = ga_addr;
      ST_GEN_B: rd_addr = gb_addr;
      default:  rd_addr = item_addr;
    endcase
  end

  // Toggle on draw, and the fade rule on the second pass. A cell of zero
  // always lands on zero through the fade branch.
  assign draw_val = (rd_data_r == LIVE) ? LIVE - fade_r : LIVE;
  assign fade_val = nam_rd_r ? LIVE
                  : (({1'b0, rd_data_r} < {fade_r, 1'b0}) ? 8'd0 : rd_data_r - fade_r);

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    st_nxt  = st_r;
    clr_nxt = clr_r;
    gy_nxt  = gy_r;
    gk_nxt  = gk_r;
    gr_nxt  = gr_r;
    res_nxt = res_r;
    cell_we = 1'b0;
    cell_wa = item_addr;
    cell_wd = in_value;

    case (st_r)
      ST_CLEAR: begin
        cell_we = 1'b1;
        cell_wa = clr_r;
        cell_wd = 8'd0;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == LAST_ADDR) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE, ST_RESP: begin
        if (accept) begin
          case (in_func)
            FUNC_LOAD: begin
              cell_we = 1'b1;
              res_nxt = in_value;
              st_nxt  = ST_RESP;
            end
            FUNC_DRAW: begin
              st_nxt = ST_DRAW;
            end
            FUNC_STEP: begin
              gy_nxt = '0;
              gk_nxt = '0;
              gr_nxt = ROW_ABOVE;
              st_nxt = ST_GEN_A;
            end
            FUNC_READ: begin
              st_nxt = ST_READ;
            end
            default: begin
              st_nxt = ST_RESP;
            end
          endcase
        end else if (st_r == ST_RESP && out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        res_nxt = rd_data_r;
        st_nxt  = ST_RESP;
      end
      ST_DRAW: begin
        cell_we = 1'b1;
        cell_wa = item_addr_r;
        cell_wd = draw_val;
        res_nxt = draw_val;
        st_nxt  = ST_RESP;
      end
      ST_GEN_A: begin
        case (gr_r)
          ROW_ABOVE:  gr_nxt = ROW_CENTER;
          ROW_CENTER: gr_nxt = ROW_BELOW;
          default: begin
            gr_nxt = ROW_ABOVE;
            if (gk_r == {1'b0, w_used} + (CRD_W+1)'(1)) begin
              gk_nxt = '0;
              if (gy_r == h_last) begin
                st_nxt = ST_DRAIN_A;
              end else begin
                gy_nxt = gy_r + crd_t'(1);
              end
            end else begin
              gk_nxt = gk_r + (CRD_W+1)'(1);
            end
          end
        endcase
      end
      ST_DRAIN_A: begin
        // The last liveness bits must be in the map before it is read.
        if (!win_busy) begin
          gy_nxt = '0;
          gk_nxt = '0;
          st_nxt = ST_GEN_B;
        end
      end
      ST_GEN_B: begin
        if (gk_r[CRD_W-1:0] == w_last) begin
          gk_nxt = '0;
          if (gy_r == h_last) begin
            st_nxt = ST_DRAIN_B;
          end else begin
            gy_nxt = gy_r + crd_t'(1);
          end
        end else begin
          gk_nxt = gk_r + (CRD_W+1)'(1);
        end
      end
      ST_DRAIN_B: begin
        res_nxt = 8'd0;
        st_nxt  = ST_RESP;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // Fade pass write-back, in the cycle after its read. Each cell is
    // touched once, so no read ever meets a pending write to it.
    if (wb_v_r) begin
      cell_we = 1'b1;
      cell_wa = wb_addr_r;
      cell_wd = fade_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      clr_r  <= '0;
      gy_r   <= '0;
      gk_r   <= '0;
      gr_r   <= ROW_ABOVE;
      wb_v_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      gy_r   <= gy_nxt;
      gk_r   <= gk_nxt;
      gr_r   <= gr_nxt;
      wb_v_r <= (st_r == ST_GEN_B);
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    wb_addr_r <= gb_addr;
    if (accept) begin
      item_addr_r <= item_addr;
    end
  end

  // ---------------------------------------------------------------------
  // Memories: cell intensities and the next-generation liveness map.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    rd_data_r <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (eval.valid) begin
      nam_mem[cell_addr(eval.x, eval.y)] <= eval.alive;
    end
    nam_rd_r <= nam_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Output register. A result moves out of the response state whenever
  // the register is empty or its beat is being taken.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_RESP && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = 1'b1;

`ifndef NO_ASSERTIONS
  a_clear_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !in_tready)
    else $error("item taken during the memory clear");

  a_step_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_STEP) |=> (st_r == ST_GEN_A))
    else $error("step beat did not start the neighborhood pass");

  a_eval_in_pass_a: assert property (@(posedge clk) disable iff (!rst_n)
    eval.valid |-> (st_r == ST_GEN_A || st_r == ST_DRAIN_A))
    else $error("liveness written outside the neighborhood pass");

  a_map_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_GEN_B) |-> !win_busy)
    else $error("fade pass started with liveness still in flight");

  a_wb_in_pass_b: assert property (@(posedge clk) disable iff (!rst_n)
    wb_v_r |-> (st_r == ST_GEN_B || st_r == ST_DRAIN_B))
    else $error("fade write-back outside the fade pass");
`endif

endmodule

### sim/tb_life_grid_step_with_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_grid_step_with_fade
//
// Self-checking bench for the fading life grid. A behavioral copy of the grid
// in the bench predicts every result beat as items are accepted. A checker
// compares each result beat against the oldest prediction. Directed tests
// cover the field extremes and the size and fade corner cases. Random worlds
// on mostly small grids then seed cells, draw, step and read back, with random
// idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_life_grid_step_with_fade;
  import lgsf_pkg::*;

  localparam int GRID_MAX_W   = MAX_WIDTH_DEF;
  localparam int GRID_MAX_H   = MAX_HEIGHT_DEF;
  localparam int CELL_COUNT   = GRID_MAX_W * GRID_MAX_H;
  localparam int RANDOM_ITEMS = 410;
  // The limit sits well above a full 64x64 step and the clearing pass after
  // reset. No correct run goes anywhere near it without a beat.
  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct {
    logic [7:0] value;
    logic       accepted;
  } result_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // cell_x[5:0], cell_y[11:6], cell_value[19:12], zeros
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // read_value[7:0]
  logic        out_tuser;  // accepted[0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  life_grid_step_with_fade dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Bench copy of the grid and of the three registers.
  logic [7:0] cell_model [0:CELL_COUNT-1];
  logic       alive_next [0:CELL_COUNT-1];
  logic [6:0] grid_w_reg;
  logic [6:0] grid_h_reg;
  logic [7:0] fade_reg;

  result_beat_t pending_results[$];
  result_beat_t oldest_result;

  int  mismatches     = 0;
  int  beats_checked  = 0;
  int  items_sent     = 0;
  int  settings_used  = 0;
  int  func_count [4] = '{0, 0, 0, 0};
  int  quiet_cycles   = 0;
  bit  in_idle_en     = 1'b0;
  bit  out_idle_en    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Grid predictor.
  // --------------------------------------------------------------------------

  function automatic void grid_reset();
    for (int i = 0; i < CELL_COUNT; i++) begin
      cell_model[i] = 8'h00;
      alive_next[i] = 1'b0;
    end
    grid_w_reg = 7'd64;
    grid_h_reg = 7'd64;
    fade_reg   = 8'd255;
  endfunction

  // A size of zero acts as one, and sizes past the array act as the maximum.
  function automatic int unsigned grid_cols();
    if (grid_w_reg == 0) return 1;
    if (grid_w_reg > GRID_MAX_W) return GRID_MAX_W;
    return grid_w_reg;
  endfunction

  function automatic int unsigned grid_rows();
    if (grid_h_reg == 0) return 1;
    if (grid_h_reg > GRID_MAX_H) return GRID_MAX_H;
    return grid_h_reg;
  endfunction

  // One B3S23 generation with wrap on both axes. On grids narrower or shorter
  // than three, the same cell shows up several times among the neighbors and
  // is counted each time. Cells outside the area in use are left alone.
  function automatic void grid_generation();
    int unsigned w, h, cnt, nx, ny, idx, cur, fade2;
    w = grid_cols();
    h = grid_rows();
    fade2 = 2 * fade_reg;
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        cnt = 0;
        for (int unsigned oy = 0; oy < 3; oy++) begin
          for (int unsigned ox = 0; ox < 3; ox++) begin
            if (!(oy == 1 && ox == 1)) begin
              ny = (y + h + oy - 1) % h;
              nx = (x + w + ox - 1) % w;
              if (cell_model[ny * GRID_MAX_W + nx] == LIVE) cnt++;
            end
          end
        end
        idx = y * GRID_MAX_W + x;
        alive_next[idx] = (cnt == 3) || (cell_model[idx] == LIVE && cnt == 2);
      end
    end
    // Survivors and births go to full intensity; the rest fade, and drop to
    // zero once they sit below twice the fade step.
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        idx = y * GRID_MAX_W + x;
        cur = cell_model[idx];
        if (alive_next[idx]) begin
          cell_model[idx] = LIVE;
        end else if (cur != 0) begin
          if (cur < fade2) cell_model[idx] = 8'h00;
          else cell_model[idx] = 8'(cur - fade_reg);
        end
      end
    end
  endfunction

  // Carries out one item on the bench grid and returns its read_value.
  function automatic logic [7:0] apply_cell_item(func_t func, logic [5:0] x,
                                                 logic [5:0] y, logic [7:0] value);
    int unsigned cx, cy, idx;
    logic [7:0]  res;
    cx = x;
    cy = y;
    if (cx > grid_cols() - 1) cx = grid_cols() - 1;
    if (cy > grid_rows() - 1) cy = grid_rows() - 1;
    idx = cy * GRID_MAX_W + cx;
    res = 8'h00;
    case (func)
      FUNC_LOAD: begin
        cell_model[idx] = value;
        res = value;
      end
      FUNC_DRAW: begin
        if (cell_model[idx] == LIVE) cell_model[idx] = LIVE - fade_reg;
        else cell_model[idx] = LIVE;
        res = cell_model[idx];
      end
      FUNC_STEP: grid_generation();
      FUNC_READ: res = cell_model[idx];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers. Inputs move on the falling edge; handshakes are judged on
  // the rising edge.
  // --------------------------------------------------------------------------

  // Sends one item and records its prediction once the beat is taken. Valid
  // is left high after the beat so back-to-back items need no gap.
  task automatic send_cell_item(input func_t func, input logic [5:0] x,
                                input logic [5:0] y, input logic [7:0] value);
    int           gap;
    result_beat_t beat;
    gap = 0;
    if (in_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, value, y, x};
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    beat.value    = apply_cell_item(func, x, y, value);
    beat.accepted = 1'b1;
    pending_results.push_back(beat);
    func_count[func]++;
    items_sent++;
  endtask

  // Holds the item channel quiet until every predicted beat has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t index, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_GRID_WIDTH:  grid_w_reg = data[6:0];
      REG_GRID_HEIGHT: grid_h_reg = data[6:0];
      REG_FADE_STEP:   fade_reg   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input logic [7:0] w, input logic [7:0] h,
                          input logic [7:0] fade);
    write_register(REG_GRID_WIDTH, w);
    write_register(REG_GRID_HEIGHT, h);
    write_register(REG_FADE_STEP, fade);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, the checker and the watchdog.
  // --------------------------------------------------------------------------

  initial begin
    int burst;
    burst = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (burst == 0 && out_idle_en && $urandom_range(0, 3) == 0)
        burst = $urandom_range(1, 10);
      if (burst > 0) begin
        out_tready <= 1'b0;
        burst--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual value %02h accepted %0b",
                 $time, out_tdata, out_tuser);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_tdata !== oldest_result.value) begin
          mismatches++;
          $display("%0t: read_value mismatch, expected %02h, actual %02h",
                   $time, oldest_result.value, out_tdata);
        end
        if (out_tuser !== oldest_result.accepted) begin
          mismatches++;
          $display("%0t: accepted mismatch, expected %0b, actual %0b",
                   $time, oldest_result.accepted, out_tuser);
        end
      end
    end
  end

  // Any beat on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("life_grid_step_with_fade verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset sizes and fade: cells read zero, field extremes load and read back,
  // a draw toggles a live cell to 255 minus 255 and back, and one full-size
  // step kills a lone cell and clears a trail below twice the fade step.
  task automatic test_reset_defaults();
    send_cell_item(FUNC_READ, 6'd0,  6'd0,  8'h00);
    send_cell_item(FUNC_READ, 6'd63, 6'd63, 8'hFF);
    send_cell_item(FUNC_LOAD, 6'd0,  6'd0,  8'hFF);
    send_cell_item(FUNC_LOAD, 6'd63, 6'd63, 8'hAA);
    send_cell_item(FUNC_LOAD, 6'd21, 6'd42, 8'h55);
    send_cell_item(FUNC_LOAD, 6'd42, 6'd21, 8'h00);
    send_cell_item(FUNC_READ, 6'd63, 6'd63, 8'h00);
    send_cell_item(FUNC_DRAW, 6'd0,  6'd0,  8'h00);
    send_cell_item(FUNC_DRAW, 6'd0,  6'd0,  8'h00);
    send_cell_item(FUNC_READ, 6'd21, 6'd42, 8'h00);
    send_cell_item(FUNC_STEP, 6'd0,  6'd0,  8'h00);
    send_cell_item(FUNC_READ, 6'd0,  6'd0,  8'h00);
    send_cell_item(FUNC_READ, 6'd63, 6'd63, 8'h00);
  endtask

  // Size registers at zero and past the maximum, a fade step of zero, and a
  // two-by-one grid where a neighbor is the same cell several times over.
  // Coordinates past the grid clamp to the last column and row.
  task automatic test_size_corners();
    drain_results();
    set_grid(8'd0, 8'd0, 8'd0);
    send_cell_item(FUNC_LOAD, 6'd63, 6'd63, 8'hFF);
    send_cell_item(FUNC_STEP, 6'd0,  6'd0,  8'h00);
    send_cell_item(FUNC_READ, 6'd17, 6'd9,  8'h00);
    send_cell_item(FUNC_DRAW, 6'd0,  6'd0,  8'h00);

    drain_results();
    set_grid(8'd127, 8'd100, 8'd1);
    send_cell_item(FUNC_DRAW, 6'd63, 6'd63, 8'h00);
    send_cell_item(FUNC_DRAW, 6'd63, 6'd63, 8'h00);
    send_cell_item(FUNC_READ, 6'd63, 6'd63, 8'h00);

    drain_results();
    set_grid(8'd2, 8'd1, 8'd100);
    send_cell_item(FUNC_LOAD, 6'd1, 6'd0, 8'hFF);
    send_cell_item(FUNC_LOAD, 6'd0, 6'd0, 8'hFF);
    send_cell_item(FUNC_STEP, 6'd0, 6'd0, 8'h00);
    send_cell_item(FUNC_READ, 6'd5, 6'd5, 8'h00);
  endtask

  // Random worlds. Each world drains the pipeline, picks a grid size and fade
  // step, seeds cells and then mixes loads, draws, steps and reads with a
  // little noise at arbitrary coordinates. Most grids are small so steps stay
  // cheap; one world runs at full size with only a couple of steps.
  task automatic test_random_worlds();
    int          sent, world, seeds, body, pick, steps, step_cap;
    logic [7:0]  w, h, fade;
    logic [5:0]  x, y;
    logic [7:0]  value;
    func_t       func;
    sent  = 0;
    world = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();

      // Sizes: mostly 1..12, sometimes zero, sometimes past the maximum with
      // the other side kept small, and one full-size world.
      w = 8'($urandom_range(1, 12));
      h = 8'($urandom_range(1, 12));
      pick = $urandom_range(0, 9);
      if (pick == 0) w = 8'd0;
      else if (pick == 1) h = 8'd0;
      else if (pick == 2) begin
        w = 8'($urandom_range(65, 127));
        h = 8'($urandom_range(1, 4));
      end else if (pick == 3) begin
        h = 8'($urandom_range(65, 127));
        w = 8'($urandom_range(1, 4));
      end
      step_cap = 1000;
      if (world == 4) begin
        w = 8'd64;
        h = 8'd64;
        step_cap = 2;
      end

      pick = $urandom_range(0, 9);
      if (pick == 0) fade = 8'd0;
      else if (pick == 1) fade = 8'd1;
      else if (pick == 2) fade = 8'd255;
      else if (pick == 3) fade = 8'd128;
      else fade = 8'($urandom_range(1, 254));
      set_grid(w, h, fade);

      // The last stretch of the run goes without idling on either side.
      in_idle_en  = (RANDOM_ITEMS - sent > 70) && ($urandom_range(0, 3) != 0);
      out_idle_en = (RANDOM_ITEMS - sent > 70) && ($urandom_range(0, 3) != 0);

      seeds = $urandom_range(6, 20);
      for (int i = 0; i < seeds; i++) begin
        x = 6'($urandom_range(0, grid_cols() - 1));
        y = 6'($urandom_range(0, grid_rows() - 1));
        value = ($urandom_range(0, 9) < 7) ? LIVE : 8'($urandom_range(0, 255));
        send_cell_item(FUNC_LOAD, x, y, value);
      end

      steps = 0;
      body  = $urandom_range(15, 30);
      for (int i = 0; i < body; i++) begin
        x = 6'($urandom_range(0, grid_cols() - 1));
        y = 6'($urandom_range(0, grid_rows() - 1));
        value = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 30) func = FUNC_LOAD;
        else if (pick < 40) func = FUNC_DRAW;
        else if (pick < 58) func = FUNC_STEP;
        else func = FUNC_READ;
        if (pick < 30 && $urandom_range(0, 1) == 0) value = LIVE;
        // Noise: any function at any coordinate, out-of-range ones clamping.
        if (pick >= 88) begin
          x = 6'($urandom_range(0, 63));
          y = 6'($urandom_range(0, 63));
          case ($urandom_range(0, 3))
            0: func = FUNC_LOAD;
            1: func = FUNC_DRAW;
            2: func = FUNC_STEP;
            default: func = FUNC_READ;
          endcase
        end
        if (func == FUNC_STEP) begin
          if (steps >= step_cap) func = FUNC_READ;
          else steps++;
        end
        send_cell_item(func, x, y, value);
      end
      sent += seeds + body;
      world++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_LOAD;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data  = '0;
    grid_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed tests run with both sides idling so gaps land on every phase.
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    test_reset_defaults();
    test_size_corners();
    test_random_worlds();

    drain_results();
    repeat (20) @(posedge clk);

    $display("Ran %0d items (%0d load, %0d draw, %0d step, %0d read) over %0d grid settings.",
             items_sent, func_count[FUNC_LOAD], func_count[FUNC_DRAW],
             func_count[FUNC_STEP], func_count[FUNC_READ], settings_used);
    $display("Compared %0d result beats; %0d mismatches, %0d predictions left.",
             beats_checked, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0)
      $display("life_grid_step_with_fade verification clean");
    else
      $display("life_grid_step_with_fade verification failed");
    $finish;
  end

endmodule
